>>> hw/rtl/cmdec_pkg.sv
// ----------------------------------------------------------------------------
// cmdec_pkg
// shared types and constants of the compressed mode decoder
// ----------------------------------------------------------------------------
package cmdec_pkg;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_EOF    = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_FINISH = 2'd3
    } kind_t;

    localparam logic [7:0] FILLER_RESET = 8'h20;
    localparam logic [7:0] HDR_RUN     = 8'h80;
    localparam logic [7:0] HDR_FILL    = 8'hc0;
    localparam logic [7:0] LIT_MASK    = 8'h7f;
    localparam logic [7:0] COUNT_MASK  = 8'h3f;
    localparam logic [7:0] DESC_EOR    = 8'h80;
    localparam logic [7:0] DESC_EOF    = 8'h40;
    localparam logic [7:0] DESC_SE     = 8'h20;
    localparam logic [7:0] DESC_MASK   = 8'he0;

    localparam int COUNT_W = 6;

    // one request from front to back: emitted count times
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        logic               record_end;
        logic               error_suspected;
        logic               last;
        logic               finish_ok;
        logic [COUNT_W-1:0] count;
    } cmd_t;

endpackage

>>> hw/rtl/compressed_mode_decoder_top.sv
// ----------------------------------------------------------------------------
// compressed_mode_decoder_top
// decoder for the compressed transfer mode byte stream
// ----------------------------------------------------------------------------
// path: the first result of an item goes through the request queue, then the
//   registered output stage; throughput: one input byte per cycle; a run of n
//   bytes gives n results; input stalls once the request queue (QUEUE_DEPTH) is full
// reset: asynchronous, clears decode state and queue, filler byte returns to 0x20
module compressed_mode_decoder_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] code_byte
    input  logic        s_tuser,    // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] data_byte, [8] record_end,
                                    // [9] error_suspected, [10] finish_ok
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast,    // block_last
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata   // filler_byte
);
    import cmdec_pkg::*;

    logic push, pop, q_full, q_empty;
    cmd_t push_cmd, head_cmd;

    cmdec_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    cmdec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (pop),
        .head    (head_cmd),
        .empty   (q_empty)
    );

    cmdec_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head_cmd),
        .empty   (q_empty),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

>>> hw/rtl/cmdec_front.sv
// ----------------------------------------------------------------------------
// cmdec_front
// accepts encoded bytes and finish checks, tracks the decode phase and
// issues at most one request per accepted byte to the queue
// ----------------------------------------------------------------------------
module cmdec_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tuser,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                q_full,
    output logic                push,
    output cmdec_pkg::cmd_t     push_cmd
);
    import cmdec_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LITERAL,
        PH_REPL,
        PH_DESC
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [6:0]          literal_left_reg, literal_left_next;
    logic [COUNT_W-1:0]  run_count_reg, run_count_next;
    logic                flags_pending_reg, flags_pending_next;
    logic                pend_re_reg, pend_re_next;
    logic                pend_se_reg, pend_se_next;
    logic                eof_seen_reg, eof_seen_next;
    logic                stream_valid_reg, stream_valid_next;
    logic [7:0]          filler_reg;

    logic                accept;
    logic                cmd_valid;
    cmd_t                cmd;
    logic [7:0]          b;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign push     = accept && cmd_valid;
    assign push_cmd = cmd;

    always_comb
    begin
        logic raise;
        logic finish_ok;
        logic end_blk;
        raise     = 1'b0;
        end_blk   = 1'b0;
        finish_ok = 1'b0;

        phase_next         = phase_reg;
        literal_left_next  = literal_left_reg;
        run_count_next     = run_count_reg;
        flags_pending_next = flags_pending_reg;
        pend_re_next       = pend_re_reg;
        pend_se_next       = pend_se_reg;
        eof_seen_next      = eof_seen_reg;
        stream_valid_next  = stream_valid_reg;

        cmd_valid           = 1'b0;
        cmd.kind            = KIND_DATA;
        cmd.data            = 8'h00;
        cmd.record_end      = 1'b0;
        cmd.error_suspected = 1'b0;
        cmd.last            = 1'b1;
        cmd.finish_ok       = 1'b0;
        cmd.count           = COUNT_W'(1);

        priority if (s_tuser)
        begin
            finish_ok = stream_valid_reg && eof_seen_reg && (phase_reg == PH_HEADER)
                        && !flags_pending_reg;
            if (!finish_ok)
            begin
                stream_valid_next = 1'b0;
            end
            cmd_valid     = 1'b1;
            cmd.kind      = KIND_FINISH;
            cmd.finish_ok = finish_ok;
        end
        else if (!stream_valid_reg)
        begin
            // dropped after an error
            cmd_valid = 1'b0;
        end
        else if (eof_seen_reg)
        begin
            raise = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_LITERAL:
                begin
                    cmd_valid           = 1'b1;
                    cmd.data            = b;
                    cmd.record_end      = pend_re_reg;
                    cmd.error_suspected = pend_se_reg;
                    cmd.last            = (literal_left_reg <= 7'd1);
                    if (literal_left_reg <= 7'd1)
                    begin
                        literal_left_next = 7'd0;
                        end_blk           = 1'b1;
                    end
                    else
                    begin
                        literal_left_next = literal_left_reg - 7'd1;
                    end
                end
                PH_REPL:
                begin
                    cmd_valid           = 1'b1;
                    cmd.data            = b;
                    cmd.record_end      = pend_re_reg;
                    cmd.error_suspected = pend_se_reg;
                    cmd.count           = run_count_reg;
                    run_count_next      = '0;
                    end_blk             = 1'b1;
                end
                PH_DESC:
                begin
                    if ((b == 8'h00) || ((b & ~DESC_MASK) != 8'h00))
                    begin
                        raise = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        if ((b & DESC_EOF) != 8'h00)
                        begin
                            eof_seen_next       = 1'b1;
                            cmd_valid           = 1'b1;
                            cmd.kind            = KIND_EOF;
                            cmd.record_end      = (b & DESC_EOR) != 8'h00;
                            cmd.error_suspected = (b & DESC_SE) != 8'h00;
                        end
                        else
                        begin
                            flags_pending_next = 1'b1;
                            pend_re_next       = (b & DESC_EOR) != 8'h00;
                            pend_se_next       = (b & DESC_SE) != 8'h00;
                        end
                    end
                end
                PH_HEADER:
                begin
                    priority if (b == 8'h00)
                    begin
                        if (flags_pending_reg)
                        begin
                            raise = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DESC;
                        end
                    end
                    else if ((b & HDR_RUN) == 8'h00)
                    begin
                        literal_left_next = 7'(b & LIT_MASK);
                        phase_next        = PH_LITERAL;
                    end
                    else if ((b & COUNT_MASK) == 8'h00)
                    begin
                        raise = 1'b1;
                    end
                    else if ((b & HDR_FILL) == HDR_FILL)
                    begin
                        cmd_valid           = 1'b1;
                        cmd.data            = filler_reg;
                        cmd.record_end      = pend_re_reg;
                        cmd.error_suspected = pend_se_reg;
                        cmd.count           = COUNT_W'(b & COUNT_MASK);
                        end_blk             = 1'b1;
                    end
                    else
                    begin
                        run_count_next = COUNT_W'(b & COUNT_MASK);
                        phase_next     = PH_REPL;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end

        if (end_blk)
        begin
            flags_pending_next = 1'b0;
            pend_re_next       = 1'b0;
            pend_se_next       = 1'b0;
            phase_next         = PH_HEADER;
        end

        if (raise)
        begin
            stream_valid_next = 1'b0;
            phase_next        = PH_HEADER;
            literal_left_next = 7'd0;
            run_count_next    = '0;
            cmd_valid         = 1'b1;
            cmd.kind          = KIND_ERROR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            literal_left_reg  <= 7'd0;
            run_count_reg     <= '0;
            flags_pending_reg <= 1'b0;
            pend_re_reg       <= 1'b0;
            pend_se_reg       <= 1'b0;
            eof_seen_reg      <= 1'b0;
            stream_valid_reg  <= 1'b1;
            filler_reg        <= FILLER_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                filler_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg         <= phase_next;
                literal_left_reg  <= literal_left_next;
                run_count_reg     <= run_count_next;
                flags_pending_reg <= flags_pending_next;
                pend_re_reg       <= pend_re_next;
                pend_se_reg       <= pend_se_next;
                eof_seen_reg      <= eof_seen_next;
                stream_valid_reg  <= stream_valid_next;
            end
        end
    end

endmodule

>>> hw/rtl/cmdec_queue.sv
// ----------------------------------------------------------------------------
// cmdec_queue
// short request queue between the front and back parts
// ----------------------------------------------------------------------------
module cmdec_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cmdec_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output cmdec_pkg::cmd_t head,
    output logic            empty
);
    import cmdec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push, do_pop;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/cmdec_back.sv
// ----------------------------------------------------------------------------
// cmdec_back
// expands queued requests into result items, one per cycle while the output is
// not stalled, into a registered output stage
// ----------------------------------------------------------------------------
module cmdec_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  cmdec_pkg::cmd_t head,
    input  logic            empty,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);
    import cmdec_pkg::*;

    logic [COUNT_W-1:0] idx_reg;
    logic               valid_reg;
    logic [15:0]        data_reg;
    logic [1:0]         user_reg;
    logic               last_reg;
    logic               load;
    logic               final_rep;

    assign load      = !empty && (!valid_reg || m_tready);
    assign final_rep = (idx_reg == (head.count - COUNT_W'(1)));
    assign pop       = load && final_rep;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= final_rep ? '0 : idx_reg + 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {5'd0, head.finish_ok, head.error_suspected,
                         head.record_end, head.data};
            user_reg <= head.kind;
            last_reg <= head.last && final_rep;
        end
    end

endmodule

>>> hw/rtl/cmdec_checker.sv
// ----------------------------------------------------------------------------
// cmdec_checker
// port-level checks on the result stream of the decoder
// ----------------------------------------------------------------------------
module cmdec_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import cmdec_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

    // anything other than a data byte closes its block and carries a zero data byte
    a_nondata_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_DATA) |-> m_tlast && (m_tdata[7:0] == 8'h00))
        else $error("non-data result without block_last or with data");

    // finish_ok only on finish status
    a_ok_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_FINISH) |-> !m_tdata[10])
        else $error("finish_ok set outside finish status");

    // nothing leaves straight out of reset
    a_reset_idle: assert property (@(posedge clk)
        $past(!rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind compressed_mode_decoder_top cmdec_checker u_cmdec_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
